@@ rtl/core/colormap_piecewise_lerp_assert.svh @@
// Assertion macros used by the colormap lookup controller.
`ifndef COLORMAP_PIECEWISE_LERP_ASSERT_SVH
`define COLORMAP_PIECEWISE_LERP_ASSERT_SVH

// Same-cycle implication, checked on clk, off while arst_n is low.
`define CPL_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("colormap lookup: same-cycle check failed");

// Next-cycle implication, checked on clk, off while arst_n is low.
`define CPL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("colormap lookup: next-cycle check failed");

`endif

@@ rtl/core/cpl_pkg.sv @@
// Package: types, codes and defaults of the piecewise-linear colormap lookup.
package cpl_pkg;

	localparam int MAX_POINTS_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int SLOT_W         = 5;
	localparam int COUNT_W        = 6;
	localparam int CHAN_W         = 16;
	localparam int NUM_CHANS      = 4;
	localparam int NUM_BANKS      = 2;
	localparam int MUL_STEPS      = 16;

	localparam logic CMD_LOOKUP = 1'b0;
	localparam logic CMD_WRITE  = 1'b1;

	localparam logic CFG_PARTICLE_POINTS = 1'b0;
	localparam logic CFG_ARROW_POINTS    = 1'b1;

	typedef struct packed {
		logic        command;
		logic        bank;
		logic [4:0]  point_index;
		logic [15:0] position;
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		logic [15:0] alpha;
	} req_t;

	typedef struct packed {
		logic [15:0] out_red;
		logic [15:0] out_green;
		logic [15:0] out_blue;
		logic [15:0] out_alpha;
		logic        status;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_WREQ,
		S_WCMP,
		S_RD0,
		S_LOAD,
		S_DIV,
		S_MULI,
		S_MUL,
		S_FIN
	} state_t;

	typedef struct packed {
		logic capture;
		logic mem_wr;
		logic rd_hi;
		logic step_idx;
		logic latch_x1;
		logic load_seg;
		logic div_step;
		logic mul_start;
		logic mul_step;
		logic out_load;
		logic out_few;
	} cmd_t;

	typedef struct packed {
		logic is_write;
		logic few;
		logic le;
		logic at_end;
		logic dx_zero;
	} sts_t;

endpackage

@@ rtl/core/cpl_dp.sv @@
// Datapath: breakpoint memories, segment walk, serial divider and serial multipliers.
module cpl_dp #(
	parameter int MAX_POINTS = cpl_pkg::MAX_POINTS_DEF,
	parameter int FRAC_BITS  = cpl_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cpl_pkg::req_t                  req,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [cpl_pkg::COUNT_W-1:0]    cfg_data,
	input  cpl_pkg::cmd_t                  cmd,
	output cpl_pkg::sts_t                  sts,
	output cpl_pkg::rsp_t                  rsp
);
	import cpl_pkg::*;

	localparam int DEPTH = NUM_BANKS * MAX_POINTS;
	localparam int AW    = $clog2(DEPTH);
	localparam int IW    = $clog2(MAX_POINTS);
	localparam int QW    = CHAN_W + FRAC_BITS;
	localparam int PW    = CHAN_W + QW;
	localparam int TW    = PW - FRAC_BITS;
	localparam int VW    = TW + 2;

	logic [CHAN_W-1:0]             pos_mem [DEPTH];
	logic [NUM_CHANS*CHAN_W-1:0]   col_mem [DEPTH];

	logic [COUNT_W-1:0]            particle_q, arrow_q;
	req_t                          req_q;
	logic [IW-1:0]                 idx_q;
	logic [CHAN_W-1:0]             pos_rdata_q, x1_q;
	logic [NUM_CHANS*CHAN_W-1:0]   col_lo_q, col_hi_q;
	logic [QW-1:0]                 quo_q;
	logic [CHAN_W-1:0]             rem_q, den_q;
	logic                          neg_d_q;
	logic [CHAN_W-1:0]             c0_q [NUM_CHANS];
	logic [CHAN_W-1:0]             mr_q [NUM_CHANS];
	logic                          csn_q [NUM_CHANS];
	logic [PW-1:0]                 acc_q [NUM_CHANS];
	logic [PW-1:0]                 md_q;
	rsp_t                          rsp_q;

	logic [AW-1:0]                 base, pos_raddr, col_addr, wr_addr;
	logic [COUNT_W-1:0]            n_sel;
	logic [IW-1:0]                 nm2;
	logic                          slot_ok;
	logic [CHAN_W:0]               pd, dx, trial;
	logic [CHAN_W-1:0]             pd_mag, dx_mag;
	logic [QW-1:0]                 numer;
	logic [CHAN_W-1:0]             chan_out [NUM_CHANS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			particle_q <= '0;
			arrow_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PARTICLE_POINTS: particle_q <= cfg_data;
				CFG_ARROW_POINTS:    arrow_q    <= cfg_data;
				default:             ;
			endcase
		end
	end

	assign base      = req_q.bank ? AW'(MAX_POINTS) : '0;
	assign pos_raddr = base + AW'(idx_q) + AW'(cmd.rd_hi);
	assign col_addr  = base + AW'(idx_q);
	assign wr_addr   = base + AW'(req_q.point_index);
	assign slot_ok   = int'(req_q.point_index) < MAX_POINTS;

	assign n_sel = req_q.bank ? arrow_q : particle_q;
	assign nm2   = (int'(n_sel) > MAX_POINTS) ? IW'(MAX_POINTS - 2)
	                                           : IW'(n_sel - COUNT_W'(2));

	always_ff @(posedge clk) begin
		if (cmd.mem_wr && slot_ok) begin
			pos_mem[wr_addr] <= req_q.position;
			col_mem[wr_addr] <= {req_q.alpha, req_q.blue, req_q.green, req_q.red};
		end
		pos_rdata_q <= pos_mem[pos_raddr];
		col_lo_q    <= col_mem[col_addr];
		col_hi_q    <= col_mem[col_addr + AW'(1)];
	end

	// segment geometry from the lower end just read and the upper end kept by the walk
	assign pd     = {1'b0, req_q.position} - {1'b0, pos_rdata_q};
	assign dx     = {1'b0, x1_q} - {1'b0, pos_rdata_q};
	assign pd_mag = pd[CHAN_W] ? CHAN_W'(-pd) : pd[CHAN_W-1:0];
	assign dx_mag = dx[CHAN_W] ? CHAN_W'(-dx) : dx[CHAN_W-1:0];
	assign numer  = {pd_mag, {FRAC_BITS{1'b0}}} + QW'(dx_mag >> 1);
	assign trial  = {rem_q, quo_q[QW-1]};

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req;
		end
		if (cmd.latch_x1) begin
			x1_q <= pos_rdata_q;
		end
		if (cmd.load_seg) begin
			quo_q   <= (dx_mag == '0) ? '0 : numer;
			rem_q   <= '0;
			den_q   <= dx_mag;
			neg_d_q <= pd[CHAN_W] ^ dx[CHAN_W];
		end else if (cmd.div_step) begin
			if (trial >= {1'b0, den_q}) begin
				rem_q <= CHAN_W'(trial - {1'b0, den_q});
				quo_q <= {quo_q[QW-2:0], 1'b1};
			end else begin
				rem_q <= trial[CHAN_W-1:0];
				quo_q <= {quo_q[QW-2:0], 1'b0};
			end
		end
		if (cmd.mul_start) begin
			md_q <= PW'(quo_q);
		end else if (cmd.mul_step) begin
			md_q <= {md_q[PW-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_CHANS; i++) begin
			if (cmd.load_seg) begin
				logic [CHAN_W:0] diff;
				diff     = {1'b0, col_hi_q[i*CHAN_W +: CHAN_W]}
				         - {1'b0, col_lo_q[i*CHAN_W +: CHAN_W]};
				c0_q[i]  <= col_lo_q[i*CHAN_W +: CHAN_W];
				csn_q[i] <= diff[CHAN_W];
				mr_q[i]  <= diff[CHAN_W] ? CHAN_W'(-diff) : diff[CHAN_W-1:0];
			end else if (cmd.mul_step) begin
				mr_q[i] <= mr_q[i] >> 1;
			end
			if (cmd.mul_start) begin
				// seed with one half so the final shift rounds to nearest
				acc_q[i] <= PW'(1) << (FRAC_BITS - 1);
			end else if (cmd.mul_step && mr_q[i][0]) begin
				acc_q[i] <= acc_q[i] + md_q;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_CHANS; i++) begin
			logic [TW-1:0]        term;
			logic signed [VW-1:0] c0e, te, v;
			term = acc_q[i][PW-1:FRAC_BITS];
			c0e  = signed'({{(VW-CHAN_W){1'b0}}, c0_q[i]});
			te   = signed'({2'b00, term});
			v    = (csn_q[i] ^ neg_d_q) ? c0e - te : c0e + te;
			if (v[VW-1]) begin
				chan_out[i] = '0;
			end else if (|v[VW-2:CHAN_W]) begin
				chan_out[i] = '1;
			end else begin
				chan_out[i] = v[CHAN_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (cmd.out_few) begin
				rsp_q <= '{out_red: '0, out_green: '0, out_blue: '0,
				           out_alpha: '0, status: 1'b1};
			end else begin
				rsp_q <= '{out_red: chan_out[0], out_green: chan_out[1],
				           out_blue: chan_out[2], out_alpha: chan_out[3], status: 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.capture) begin
			idx_q <= '0;
		end else if (cmd.step_idx) begin
			idx_q <= idx_q + IW'(1);
		end
	end

	assign sts.is_write = req_q.command == CMD_WRITE;
	assign sts.few      = n_sel < COUNT_W'(2);
	assign sts.le       = pos_rdata_q <= req_q.position;
	assign sts.at_end   = idx_q == nm2;
	assign sts.dx_zero  = x1_q == pos_rdata_q;
	assign rsp          = rsp_q;

endmodule

@@ rtl/core/cpl_ctrl.sv @@
// Controller: sequences accept, breakpoint write, walk, divide, multiply and result hand-off.
`include "colormap_piecewise_lerp_assert.svh"

module cpl_ctrl #(
	parameter int FRAC_BITS = cpl_pkg::FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	input  cpl_pkg::sts_t sts,
	output cpl_pkg::cmd_t cmd
);
	import cpl_pkg::*;

	localparam int QW   = CHAN_W + FRAC_BITS;
	localparam int CNTW = $clog2(QW);

	state_t          state_q, state_d;
	logic [CNTW-1:0] cnt_q, cnt_d;
	logic            rsp_valid_q;
	logic            out_free;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = state_q != S_IDLE;
	assign rsp_valid = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.is_write) begin
					cmd.mem_wr = 1'b1;
					state_d    = S_IDLE;
				end else if (sts.few) begin
					state_d = S_FIN;
				end else begin
					state_d = S_WREQ;
				end
			end
			S_WREQ: begin
				cmd.rd_hi = 1'b1;
				state_d   = S_WCMP;
			end
			S_WCMP: begin
				if (sts.le && !sts.at_end) begin
					cmd.step_idx = 1'b1;
					state_d      = S_WREQ;
				end else begin
					cmd.latch_x1 = 1'b1;
					state_d      = S_RD0;
				end
			end
			S_RD0: begin
				state_d = S_LOAD;
			end
			S_LOAD: begin
				cmd.load_seg = 1'b1;
				cnt_d        = '0;
				state_d      = sts.dx_zero ? S_MULI : S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + CNTW'(1);
				if (cnt_q == CNTW'(QW - 1)) begin
					state_d = S_MULI;
				end
			end
			S_MULI: begin
				cmd.mul_start = 1'b1;
				cnt_d         = '0;
				state_d       = S_MUL;
			end
			S_MUL: begin
				cmd.mul_step = 1'b1;
				cnt_d        = cnt_q + CNTW'(1);
				if (cnt_q == CNTW'(MUL_STEPS - 1)) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_few  = sts.few;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	`CPL_ASSERT_NOW(a_load_into_free, cmd.out_load, !rsp_valid_q || !rsp_stall)
	`CPL_ASSERT_NEXT(a_accept_decodes, req_valid && !req_stall, state_q == S_DECODE)
	`CPL_ASSERT_NEXT(a_div_runs, state_q == S_DIV && cnt_q != CNTW'(QW - 1), state_q == S_DIV)

endmodule

@@ rtl/core/colormap_piecewise_lerp.sv @@
// Top level of the two-bank piecewise-linear RGBA colormap lookup.
//
//   port group   | direction | handshake         | payload
//   -------------+-----------+-------------------+-------------------------------
//   req          | in        | req_valid/stall   | lookup or breakpoint write
//   rsp          | out       | rsp_valid/stall   | saturated RGBA and status
//   cfg          | in        | cfg_we            | point count per bank
//
// A breakpoint write takes the accepting cycle and the memory write; the next
// transaction can be taken right after. A lookup runs from the accepting cycle
// through the result load: the walk reads one breakpoint position per request and
// compare step from the single position read port, the restoring divider retires
// one quotient bit a cycle, and the four channel multipliers add one partial
// product a cycle. Zero-width segments skip the divide. A bank with fewer than
// two points skips the walk and the arithmetic and answers with zero channels
// and the status bit set.
// Reset clears the counts and the control; breakpoint memories hold garbage until written.
// A result held under rsp_stall still lets the next transaction in; the block only
// waits in its last step when the output register is still full.
module colormap_piecewise_lerp #(
	parameter int MAX_POINTS = cpl_pkg::MAX_POINTS_DEF,
	parameter int FRAC_BITS  = cpl_pkg::FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  cpl_pkg::req_t               req,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output cpl_pkg::rsp_t               rsp,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [cpl_pkg::COUNT_W-1:0] cfg_data
);
	import cpl_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencing: accept, write, walk, divide, multiply, hand off
	cpl_ctrl #(
		.FRAC_BITS(FRAC_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// storage and arithmetic
	cpl_dp #(
		.MAX_POINTS(MAX_POINTS),
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.rsp       (rsp)
	);

endmodule
